// ===== sv/keypad_expression_calculator_top_assert.svh =====
// ----------------------------------------------------------------------------
// keypad calculator assertion macros
// shared property forms, clocked on clk and held off during rst
// ----------------------------------------------------------------------------
`ifndef KEYPAD_EXPRESSION_CALCULATOR_TOP_ASSERT_SVH
`define KEYPAD_EXPRESSION_CALCULATOR_TOP_ASSERT_SVH

// condition that must hold whenever pre holds, same cycle
`define KEC_ASSERT_IMPLIES(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// condition that must hold in the cycle after pre holds
`define KEC_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ===== sv/kec_pkg.sv =====
// ----------------------------------------------------------------------------
// kec_pkg
// key codes, fixed datapath widths and the controller/datapath interface
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package kec_pkg;

  // default configuration
  localparam int DEF_BUFFER_DEPTH  = 12;
  localparam int DEF_FRACTION_BITS = 16;

  // key codes
  localparam logic [7:0] KEY_ZERO = 8'h30;
  localparam logic [7:0] KEY_NINE = 8'h39;
  localparam logic [7:0] KEY_ADD  = 8'h41;
  localparam logic [7:0] KEY_SUB  = 8'h42;
  localparam logic [7:0] KEY_DIV  = 8'h43;
  localparam logic [7:0] KEY_EQ   = 8'h44;
  localparam logic [7:0] KEY_MUL  = 8'h2A;

  // widths sized for the deepest buffer (16 keys)
  localparam int OUT_W  = 54;  // result word
  localparam int OPND_W = 53;  // signed first operand, unsigned second operand
  localparam int MAG_W  = 53;  // operand and sum magnitudes
  localparam int FULL_W = 57;  // running accumulation over every buffered key
  localparam int MUL_W  = 56;  // shift-add product with sticky overflow

  // saturation limits of the result word
  localparam logic [OUT_W-1:0] POS_LIM = {1'b0, {(OUT_W-1){1'b1}}};
  localparam logic [OUT_W-1:0] NEG_LIM = {1'b1, {(OUT_W-1){1'b0}}};

  // commands from the controller
  typedef struct packed {
    logic store;      // append the accepted key
    logic scan_init;  // start a pass over the buffer
    logic scan_step;  // take one buffered key
    logic setup;      // load operands for the arithmetic unit
    logic mul_step;   // one shift-add step
    logic div_step;   // one restoring division step
    logic finish;     // register the result word, empty the buffer
    logic err;        // result word is an error
  } cmd_t;

  // status to the controller
  typedef struct packed {
    logic key_entry;  // key code is a digit or an operator
    logic key_eq;     // key code is equals
    logic scan_end;   // every buffered key has been taken
    logic found;      // an operator was seen in the buffer
    logic op_sum;     // operator is add or subtract
    logic op_mul;
    logic op_div;
    logic b_zero;     // second operand is zero
    logic iter_last;  // last step of the arithmetic loop
  } stat_t;

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= KEY_ZERO) && (c <= KEY_NINE);
  endfunction

  function automatic logic is_entry(input logic [7:0] c);
    return is_digit(c) || (c == KEY_ADD) || (c == KEY_SUB) ||
           (c == KEY_DIV) || (c == KEY_MUL);
  endfunction

endpackage

// ===== sv/kec_ctrl.sv =====
// ----------------------------------------------------------------------------
// kec_ctrl
// sequencer: key entry, buffer scan, arithmetic loop and result strobe
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kec_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  kec_pkg::stat_t stat,
  output kec_pkg::cmd_t  cmd,
  output logic           busy
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_SETUP,
    ST_MUL,
    ST_DIV,
    ST_FINISH
  } state_t;

  state_t state;
  logic   err;

  assign busy = (state != ST_IDLE);

  // state and error register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      err   <= 1'b0;
    end else begin
      case (state)
        ST_IDLE: begin
          if (start && stat.key_eq) begin
            state <= ST_SCAN;
            err   <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (stat.scan_end) begin
            state <= ST_SETUP;
          end
        end
        ST_SETUP: begin
          if (!stat.found || (stat.op_div && stat.b_zero)) begin
            err   <= 1'b1;
            state <= ST_FINISH;
          end else if (stat.op_mul) begin
            state <= ST_MUL;
          end else if (stat.op_div) begin
            state <= ST_DIV;
          end else if (stat.op_sum) begin
            state <= ST_FINISH;
          end else begin
            err   <= 1'b1;
            state <= ST_FINISH;
          end
        end
        ST_MUL: begin
          if (stat.iter_last) begin
            state <= ST_FINISH;
          end
        end
        ST_DIV: begin
          if (stat.iter_last) begin
            state <= ST_FINISH;
          end
        end
        ST_FINISH: begin
          state <= ST_IDLE;
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // command decode
  always_comb begin
    cmd = '0;
    case (state)
      ST_IDLE: begin
        cmd.store     = start && stat.key_entry;
        cmd.scan_init = start && stat.key_eq;
      end
      ST_SCAN: begin
        cmd.scan_step = !stat.scan_end;
      end
      ST_SETUP: begin
        cmd.setup = 1'b1;
      end
      ST_MUL: begin
        cmd.mul_step = 1'b1;
      end
      ST_DIV: begin
        cmd.div_step = 1'b1;
      end
      ST_FINISH: begin
        cmd.finish = 1'b1;
        cmd.err    = err;
      end
      default: begin
        cmd = '0;
      end
    endcase
  end

endmodule

// ===== sv/kec_dp.sv =====
// ----------------------------------------------------------------------------
// kec_dp
// key buffer, decimal scan, bit-serial multiply/divide and result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module kec_dp #(
  parameter int BUFFER_DEPTH  = kec_pkg::DEF_BUFFER_DEPTH,
  parameter int FRACTION_BITS = kec_pkg::DEF_FRACTION_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [7:0]                        key_code,
  input  kec_pkg::cmd_t                     cmd,
  output kec_pkg::stat_t                    stat,
  output logic signed [kec_pkg::OUT_W-1:0]  result_value,
  output logic                              error_flag,
  output logic                              done
);

  localparam int OUT_W     = kec_pkg::OUT_W;
  localparam int OPND_W    = kec_pkg::OPND_W;
  localparam int MAG_W     = kec_pkg::MAG_W;
  localparam int FULL_W    = kec_pkg::FULL_W;
  localparam int MUL_W     = kec_pkg::MUL_W;
  localparam int IDX_W     = (BUFFER_DEPTH > 1) ? $clog2(BUFFER_DEPTH) : 1;
  localparam int CNT_W     = $clog2(BUFFER_DEPTH + 1);
  localparam int DIV_W     = MAG_W + FRACTION_BITS;
  localparam int ITER_W    = $clog2(DIV_W);
  localparam int SAT_SHIFT = OUT_W - 1 - FRACTION_BITS;
  localparam logic [MUL_W-1:0] MUL_CAP = MUL_W'(1) << OUT_W;

  // key storage
  logic [7:0]       key_buffer [BUFFER_DEPTH];
  logic [CNT_W-1:0] key_count;

  // scan state
  logic [CNT_W-1:0]         idx;
  logic signed [FULL_W-1:0] full;
  logic signed [OPND_W-1:0] a;
  logic [OPND_W-1:0]        b;
  logic [7:0]               op;
  logic                     found;

  // arithmetic state
  logic              sign;
  logic              ovf;
  logic [MUL_W-1:0]  acc;
  logic [MAG_W-1:0]  mier;
  logic [MAG_W-1:0]  rem;
  logic [DIV_W-1:0]  quo;
  logic [ITER_W-1:0] iter;

  // combinational terms
  logic [7:0]               cur_key;
  logic                     cur_digit;
  logic signed [FULL_W-1:0] cur_ext;
  logic signed [FULL_W-1:0] full_next;
  logic [OPND_W-1:0]        b_next;
  logic [MAG_W-1:0]         ua;
  logic signed [OPND_W:0]   sum;
  logic [MAG_W-1:0]         sum_mag;
  logic                     is_sub;
  logic                     is_div;
  logic [MUL_W-1:0]         acc_next;
  logic [MAG_W:0]           rem_sh;
  logic [MAG_W:0]           rem_sub;
  logic                     rem_ge;
  logic                     big;
  logic [OUT_W-1:0]         mag_out;
  logic [OUT_W-1:0]         value;

  // one buffered key: decimal step on the whole prefix and on the digit run
  assign cur_key   = key_buffer[idx[IDX_W-1:0]];
  assign cur_digit = kec_pkg::is_digit(cur_key);
  assign cur_ext   = FULL_W'(cur_key) - FULL_W'(kec_pkg::KEY_ZERO);
  assign full_next = (full << 3) + (full << 1) + cur_ext;
  assign b_next    = (b << 3) + (b << 1) + OPND_W'(cur_key[3:0]);

  // operand magnitudes and the sum for add/subtract
  assign is_sub  = (op == kec_pkg::KEY_SUB);
  assign is_div  = (op == kec_pkg::KEY_DIV);
  assign ua      = a[OPND_W-1] ? MAG_W'(-a) : MAG_W'(a);
  assign sum     = is_sub ? ({a[OPND_W-1], a} - {1'b0, b})
                          : ({a[OPND_W-1], a} + {1'b0, b});
  assign sum_mag = sum[OPND_W] ? MAG_W'(-sum) : MAG_W'(sum);

  // msb-first shift-add multiply step
  assign acc_next = (acc << 1) + (mier[MAG_W-1] ? MUL_W'(ua) : '0);

  // restoring division step
  assign rem_sh  = {rem, quo[DIV_W-1]};
  assign rem_sub = rem_sh - {1'b0, b};
  assign rem_ge  = (rem_sh >= {1'b0, b});

  // scaling and saturation of the final magnitude
  always_comb begin
    if (is_div) begin
      big     = ((quo >> (OUT_W - 1)) != '0);
      mag_out = OUT_W'(quo);
    end else begin
      big     = ovf || ((acc >> SAT_SHIFT) != '0);
      mag_out = OUT_W'(acc << FRACTION_BITS);
    end
    if (sign) begin
      value = big ? kec_pkg::NEG_LIM : OUT_W'(-mag_out);
    end else begin
      value = big ? kec_pkg::POS_LIM : mag_out;
    end
  end

  // status
  always_comb begin
    stat.key_entry = kec_pkg::is_entry(key_code);
    stat.key_eq    = (key_code == kec_pkg::KEY_EQ);
    stat.scan_end  = (idx == key_count);
    stat.found     = found;
    stat.op_sum    = (op == kec_pkg::KEY_ADD) || is_sub;
    stat.op_mul    = (op == kec_pkg::KEY_MUL);
    stat.op_div    = is_div;
    stat.b_zero    = (b == '0);
    stat.iter_last = (iter == '0);
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      key_count <= '0;
      idx       <= '0;
      found     <= 1'b0;
      ovf       <= 1'b0;
      iter      <= '0;
      done      <= 1'b0;
    end else begin
      done <= cmd.finish;
      if (cmd.store && (key_count < CNT_W'(BUFFER_DEPTH))) begin
        key_count <= key_count + 1'b1;
      end
      if (cmd.finish) begin
        key_count <= '0;
      end
      if (cmd.scan_init) begin
        idx   <= '0;
        found <= 1'b0;
      end
      if (cmd.scan_step) begin
        idx <= idx + 1'b1;
        if (!cur_digit) begin
          found <= 1'b1;
        end
      end
      if (cmd.setup) begin
        ovf  <= 1'b0;
        iter <= is_div ? ITER_W'(DIV_W - 1) : ITER_W'(MAG_W - 1);
      end
      if (cmd.mul_step || cmd.div_step) begin
        iter <= iter - 1'b1;
      end
      if (cmd.mul_step && !ovf && (acc_next > MUL_CAP)) begin
        ovf <= 1'b1;
      end
    end
  end

  // key buffer write
  always_ff @(posedge clk) begin
    if (cmd.store && (key_count < CNT_W'(BUFFER_DEPTH))) begin
      key_buffer[key_count[IDX_W-1:0]] <= key_code;
    end
  end

  // operand and arithmetic payload
  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      full <= '0;
      b    <= '0;
    end
    if (cmd.scan_step) begin
      full <= full_next;
      if (cur_digit) begin
        b <= b_next;
      end else begin
        a  <= OPND_W'(full);
        op <= cur_key;
        b  <= '0;
      end
    end
    if (cmd.setup) begin
      acc  <= stat.op_sum ? MUL_W'(sum_mag) : '0;
      sign <= stat.op_sum ? sum[OPND_W] : a[OPND_W-1];
      mier <= MAG_W'(b);
      quo  <= DIV_W'(ua) << FRACTION_BITS;
      rem  <= '0;
    end
    if (cmd.mul_step) begin
      mier <= mier << 1;
      if (!ovf) begin
        acc <= acc_next;
      end
    end
    if (cmd.div_step) begin
      rem <= rem_ge ? rem_sub[MAG_W-1:0] : rem_sh[MAG_W-1:0];
      quo <= {quo[DIV_W-2:0], rem_ge};
    end
    if (cmd.finish) begin
      result_value <= cmd.err ? '0 : value;
      error_flag   <= cmd.err;
    end
  end

endmodule

// ===== sv/keypad_expression_calculator_top.sv =====
// ----------------------------------------------------------------------------
// keypad_expression_calculator_top
// four-function keypad calculator with signed fixed-point result
// ----------------------------------------------------------------------------
// A key word is taken when start is high and busy is low. Digit and operator
// keys are stored while the buffer has room and give no result; other keys
// except equals are dropped. Equals (D) raises busy and evaluates the buffer:
// a scan over the buffered keys, a setup state, then 53 shift-add steps for
// multiply or 53 + FRACTION_BITS restoring-division steps for divide, and a
// finish state that forms the word. The scan takes one key per cycle and the
// multiply/divide loop takes one bit per cycle, and these set the time.
// The result word is on result_value and error_flag with done high for a
// single cycle and holds until the next result; the receiver cannot stall
// it, and busy is low again in that same cycle. After a result the key
// buffer is empty.
`timescale 1ns / 1ps

module keypad_expression_calculator_top #(
  parameter int BUFFER_DEPTH  = kec_pkg::DEF_BUFFER_DEPTH,
  parameter int FRACTION_BITS = kec_pkg::DEF_FRACTION_BITS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              start,
  output logic                              busy,
  input  logic [7:0]                        key_code,
  output logic signed [kec_pkg::OUT_W-1:0]  result_value,
  output logic                              error_flag,
  output logic                              done
);

  kec_pkg::cmd_t  cmd;
  kec_pkg::stat_t stat;

  // sequencer
  kec_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .cmd   (cmd),
    .busy  (busy)
  );

  // datapath
  kec_dp #(
    .BUFFER_DEPTH  (BUFFER_DEPTH),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .key_code     (key_code),
    .cmd          (cmd),
    .stat         (stat),
    .result_value (result_value),
    .error_flag   (error_flag),
    .done         (done)
  );

  // checks
  `include "keypad_expression_calculator_top_assert.svh"

  `KEC_ASSERT_IMPLIES(a_err_word_zero, done && error_flag, result_value == '0, "error word not zero")
  `KEC_ASSERT_IMPLIES(a_done_idle, done, !busy, "busy still high with result word")
  `KEC_ASSERT_IMPLIES(a_done_from_eval, done, $past(busy), "result word without evaluation")
  `KEC_ASSERT_NEXT(a_eq_starts_eval, start && !busy && key_code == kec_pkg::KEY_EQ, busy, "equals key did not start evaluation")

endmodule
